@@ rtl/tpsd_pkg.sv @@
package tpsd_pkg;

	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
	localparam int FILL_W      = $clog2(PAL_ENTRIES + 1);
	localparam int PIX_W       = 30;
	localparam int CFG_IDX_W   = 3;

	localparam logic [2:0] CFG_COLOR_MAPPED = 3'd0;
	localparam logic [2:0] CFG_RUN_LENGTH   = 3'd1;
	localparam logic [2:0] CFG_PIXEL_BYTES  = 3'd2;
	localparam logic [2:0] CFG_MAP_BYTES    = 3'd3;
	localparam logic [2:0] CFG_TOTAL_PIXELS = 3'd4;

	localparam logic [1:0] MODE_PALETTE = 2'd0;
	localparam logic [1:0] MODE_IMAGE   = 2'd1;
	localparam logic [1:0] MODE_FRAME   = 2'd2;

	typedef struct packed {
		logic             color_mapped;
		logic             run_length;
		logic [2:0]       pixel_bytes;
		logic [2:0]       map_bytes;
		logic [PIX_W-1:0] total_pixels;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [31:0]       data;
	} pal_wr_t;

	typedef struct packed {
		logic        valid;
		logic        mapped;
		logic        idx_ok;
		logic [31:0] color;
		logic [7:0]  repeat_cnt;
		logic        frame_done;
		logic        clipped;
	} res_t;

	function automatic logic [2:0] clamp_len(input logic [2:0] n);
		logic [2:0] r;
		r = n;
		if (n == 3'd0)
			r = 3'd1;
		else if (n > 3'd4)
			r = 3'd4;
		return r;
	endfunction

	function automatic logic [7:0] widen5(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

	function automatic logic [31:0] to_argb(input logic [31:0] v, input logic [2:0] len);
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [31:0] r;
		lo = v[7:0];
		hi = v[15:8];
		case (len)
			3'd2:    r = {(hi[7] ? 8'hFF : 8'h00), widen5(hi[6:2]),
			              widen5({hi[1:0], lo[7:5]}), widen5(lo[4:0])};
			3'd3:    r = {8'hFF, v[23:0]};
			3'd4:    r = v;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/tga_pixel_stream_decoder.sv @@
// A pixel-yielding request is registered into stage 1 with its palette read, then into the
// output registers. Throughput: one byte per cycle unless the output stalls; palette writes
// and lookups share one registered-read RAM port pair, read and written only at acceptance,
// so no stall is ever generated internally. Reset: control state, frame counters and config
// registers return to defaults at once; palette contents are undefined until written.
module tga_pixel_stream_decoder
	import tpsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [7:0]           data_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          argb,
	output logic [7:0]           repeat_res,
	output logic                 frame_done,
	output logic                 clipped,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data
);

	cfg_t              cfg_q;
	pal_wr_t           pal_wr;
	logic              rd_en;
	logic [PAL_AW-1:0] rd_addr;
	logic [31:0]       rd_data;
	res_t              res;
	res_t              res_s1;
	logic              out_valid_q;
	logic [31:0]       argb_q;
	logic [7:0]        repeat_q;
	logic              frame_done_q;
	logic              clipped_q;
	logic              adv;
	logic              fire;
	logic [31:0]       color_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mapped <= 1'b0;
			cfg_q.run_length   <= 1'b0;
			cfg_q.pixel_bytes  <= 3'd3;
			cfg_q.map_bytes    <= 3'd3;
			cfg_q.total_pixels <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COLOR_MAPPED: cfg_q.color_mapped <= cfg_data[0];
				CFG_RUN_LENGTH:   cfg_q.run_length   <= cfg_data[0];
				CFG_PIXEL_BYTES:  cfg_q.pixel_bytes  <= cfg_data[2:0];
				CFG_MAP_BYTES:    cfg_q.map_bytes    <= cfg_data[2:0];
				CFG_TOTAL_PIXELS: cfg_q.total_pixels <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv      = res_s1.valid && (!out_valid_q || !out_stall);
	assign in_stall = res_s1.valid && !adv;
	assign fire     = in_valid && !in_stall;

	tpsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.mode      (mode),
		.data_byte (data_byte),
		.cfg       (cfg_q),
		.pal_wr    (pal_wr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.res       (res)
	);

	tpsd_palette u_palette (
		.clk     (clk),
		.wr      (pal_wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stage 1 waits on the palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else if (fire) begin
			if (res.valid)
				res_s1 <= res;
			else
				res_s1.valid <= 1'b0;
		end else if (adv) begin
			res_s1.valid <= 1'b0;
		end
	end

	always_comb begin
		if (!res_s1.mapped)
			color_s1 = res_s1.color;
		else if (res_s1.idx_ok)
			color_s1 = rd_data;
		else
			color_s1 = 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			argb_q       <= color_s1;
			repeat_q     <= res_s1.repeat_cnt;
			frame_done_q <= res_s1.frame_done;
			clipped_q    <= res_s1.clipped;
		end
	end

	assign out_valid  = out_valid_q;
	assign argb       = argb_q;
	assign repeat_res = repeat_q;
	assign frame_done = frame_done_q;
	assign clipped    = clipped_q;

endmodule

@@ rtl/tpsd_palette.sv @@
module tpsd_palette
	import tpsd_pkg::*;
(
	input  logic              clk,
	input  pal_wr_t           wr,
	input  logic              rd_en,
	input  logic [PAL_AW-1:0] rd_addr,
	output logic [31:0]       rd_data
);

	logic [31:0] mem [PAL_ENTRIES];
	logic [31:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en)
			mem[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/tpsd_ctrl.sv @@
module tpsd_ctrl
	import tpsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [1:0]        mode,
	input  logic [7:0]        data_byte,
	input  cfg_t              cfg,
	output pal_wr_t           pal_wr,
	output logic              rd_en,
	output logic [PAL_AW-1:0] rd_addr,
	output res_t              res
);

	logic [FILL_W-1:0] fill_q, fill_d;
	logic [23:0]       buf_q, buf_d;
	logic [1:0]        phase_q, phase_d;
	logic [7:0]        left_q, left_d;
	logic              is_run_q, is_run_d;
	logic              hdr_q, hdr_d;
	logic [PIX_W-1:0]  done_q, done_d;

	logic [2:0]        len;
	logic [31:0]       v;
	logic              complete;
	logic [PIX_W-1:0]  remaining;
	logic [7:0]        rep;
	logic [7:0]        left_n;

	always_comb begin
		fill_d    = fill_q;
		buf_d     = buf_q;
		phase_d   = phase_q;
		left_d    = left_q;
		is_run_d  = is_run_q;
		hdr_d     = hdr_q;
		done_d    = done_q;
		pal_wr    = '0;
		rd_en     = 1'b0;
		rd_addr   = '0;
		res       = '0;
		rep       = 8'd1;
		left_n    = left_q;
		remaining = cfg.total_pixels - done_q;

		len      = (mode == MODE_PALETTE) ? clamp_len(cfg.map_bytes) : clamp_len(cfg.pixel_bytes);
		v        = {8'd0, buf_q} | (32'(data_byte) << {phase_q, 3'b000});
		complete = ({1'b0, phase_q} + 3'd1) >= len;

		case (mode)
			MODE_PALETTE: begin
				if (complete) begin
					buf_d   = '0;
					phase_d = '0;
					if (fill_q < FILL_W'(PAL_ENTRIES)) begin
						pal_wr.en   = 1'b1;
						pal_wr.addr = fill_q[PAL_AW-1:0];
						pal_wr.data = to_argb(v, len);
						fill_d      = fill_q + FILL_W'(1);
					end
				end else begin
					buf_d   = v[23:0];
					phase_d = phase_q + 2'd1;
				end
			end
			MODE_IMAGE: begin
				if (done_q < cfg.total_pixels) begin
					if (cfg.run_length && hdr_q) begin
						is_run_d = data_byte[7];
						left_d   = {1'b0, data_byte[6:0]} + 8'd1;
						hdr_d    = 1'b0;
					end else if (!complete) begin
						buf_d   = v[23:0];
						phase_d = phase_q + 2'd1;
					end else begin
						buf_d   = '0;
						phase_d = '0;
						if (cfg.run_length) begin
							if (is_run_q) begin
								rep    = left_q;
								left_n = 8'd0;
							end else begin
								left_n = left_q - 8'd1;
							end
							left_d = left_n;
							if (left_n == 8'd0)
								hdr_d = 1'b1;
						end
						res.valid  = 1'b1;
						res.mapped = cfg.color_mapped;
						res.idx_ok = 32'(v[7:0]) < 32'(PAL_ENTRIES);
						res.color  = to_argb(v, len);
						if (PIX_W'(rep) > remaining) begin
							rep         = remaining[7:0];
							res.clipped = 1'b1;
						end
						res.repeat_cnt = rep;
						res.frame_done = PIX_W'(rep) == remaining;
						done_d         = done_q + PIX_W'(rep);
						rd_en          = cfg.color_mapped && res.idx_ok;
						rd_addr        = PAL_AW'(v[7:0]);
					end
				end
			end
			MODE_FRAME: begin
				fill_d   = '0;
				buf_d    = '0;
				phase_d  = '0;
				left_d   = '0;
				is_run_d = 1'b0;
				hdr_d    = 1'b1;
				done_d   = '0;
			end
			default: ;
		endcase

		if (!fire) begin
			pal_wr.en = 1'b0;
			rd_en     = 1'b0;
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			buf_q    <= '0;
			phase_q  <= '0;
			left_q   <= '0;
			is_run_q <= 1'b0;
			hdr_q    <= 1'b1;
			done_q   <= '0;
		end else if (fire) begin
			fill_q   <= fill_d;
			buf_q    <= buf_d;
			phase_q  <= phase_d;
			left_q   <= left_d;
			is_run_q <= is_run_d;
			hdr_q    <= hdr_d;
			done_q   <= done_d;
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import tpsd_pkg::*;

	localparam logic [1:0] MODE_SPARE    = 2'd3;
	localparam int         RAND_ITEMS    = 500;
	localparam int         SETTLE_CYCLES = 6;
	localparam int         TAIL_CYCLES   = 10;
	localparam int         IDLE_LIMIT    = 500;
	localparam int         MAX_PRINTS    = 100;

	typedef struct packed {
		logic [31:0] argb;
		logic [7:0]  reps;
		logic        done;
		logic        clip;
	} pixel_t;

	typedef enum logic [1:0] {ROW_REG, ROW_REQ, ROW_CHECKED} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		logic [2:0]  sel;
		logic [29:0] arg;
		pixel_t      want;
	} step_t;

	localparam pixel_t NO_PIXEL = '0;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           mode;
	logic [7:0]           data_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [31:0]          argb;
	logic [7:0]           repeat_res;
	logic                 frame_done;
	logic                 clipped;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PIX_W-1:0]     cfg_data;

	tga_pixel_stream_decoder dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// decoder state as seen from the stream
	cfg_t              regs;
	logic [31:0]       pal_mem [PAL_ENTRIES];
	logic [FILL_W-1:0] pal_fill;
	logic [23:0]       asm_buf;
	logic [1:0]        asm_phase;
	logic [7:0]        pkt_left;
	logic              pkt_run;
	logic              want_header;
	logic [PIX_W-1:0]  px_done;

	pixel_t pending_pixels[$];
	int     mismatches   = 0;
	int     bytes_sent   = 0;
	int     busy_reqs    = 0;
	int     pixels_seen  = 0;
	int     reg_writes   = 0;
	int     frames       = 0;
	int     idle_cycles  = 0;
	bit     tx_burst     = 1'b0;
	bit     rx_burst     = 1'b0;

	function automatic logic [2:0] byte_count(input logic [2:0] n);
		if (n == 3'd0)
			return 3'd1;
		return (n > 3'd4) ? 3'd4 : n;
	endfunction

	function automatic logic [31:0] unpack_color(input logic [31:0] w, input logic [2:0] len);
		logic [4:0] r5;
		logic [4:0] g5;
		logic [4:0] b5;
		r5 = w[14:10];
		g5 = w[9:5];
		b5 = w[4:0];
		case (len)
			3'd2:    return {{8{w[15]}}, r5, r5[4:2], g5, g5[4:2], b5, b5[4:2]};
			3'd3:    return {8'hFF, w[23:0]};
			3'd4:    return w;
			default: return 32'd0;
		endcase
	endfunction

	// shared byte assembly for palette and image requests
	function automatic logic take_byte(input logic [7:0] b, input logic [2:0] len,
			output logic [31:0] w);
		w = {8'h00, asm_buf} | ({24'h0, b} << (8 * asm_phase));
		if (asm_phase + 3'd1 >= len) begin
			asm_buf   = '0;
			asm_phase = '0;
			return 1'b1;
		end
		asm_buf   = w[23:0];
		asm_phase = asm_phase + 2'd1;
		return 1'b0;
	endfunction

	task automatic restart_frame();
		pal_fill    = '0;
		asm_buf     = '0;
		asm_phase   = '0;
		pkt_left    = '0;
		pkt_run     = 1'b0;
		want_header = 1'b1;
		px_done     = '0;
	endtask

	task automatic tga_decode(input logic [1:0] m, input logic [7:0] b,
			output logic has_px, output pixel_t px, output logic took);
		logic [31:0] word;
		logic [2:0]  len;
		int unsigned rep;
		int unsigned left;
		has_px = 1'b0;
		took   = 1'b0;
		px     = NO_PIXEL;
		case (m)
			MODE_FRAME: begin
				restart_frame();
			end
			MODE_PALETTE: begin
				took = 1'b1;
				len  = byte_count(regs.map_bytes);
				if (take_byte(b, len, word) && pal_fill < PAL_ENTRIES) begin
					pal_mem[pal_fill[PAL_AW-1:0]] = unpack_color(word, len);
					pal_fill = pal_fill + 1'b1;
				end
			end
			MODE_IMAGE: begin
				if (px_done < regs.total_pixels) begin
					took = 1'b1;
					if (regs.run_length && want_header) begin
						pkt_run     = b[7];
						pkt_left    = {1'b0, b[6:0]} + 8'd1;
						want_header = 1'b0;
					end else begin
						len = byte_count(regs.pixel_bytes);
						if (take_byte(b, len, word)) begin
							has_px = 1'b1;
							if (regs.color_mapped)
								px.argb = (word[7:0] < PAL_ENTRIES) ? pal_mem[word[7:0]] : 32'd0;
							else
								px.argb = unpack_color(word, len);
							rep = 1;
							if (regs.run_length) begin
								if (pkt_run) begin
									rep      = pkt_left;
									pkt_left = '0;
								end else begin
									pkt_left = pkt_left - 8'd1;
								end
								if (pkt_left == 8'd0)
									want_header = 1'b1;
							end
							left = regs.total_pixels - px_done;
							if (rep > left) begin
								rep     = left;
								px.clip = 1'b1;
							end
							px_done = px_done + PIX_W'(rep);
							px.reps = rep[7:0];
							px.done = (px_done == regs.total_pixels);
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("[%0t] pixel %0d %s: got %h, expected %h", $time, pixels_seen, what, got,
				want);
	endtask

	task automatic send_req(input logic [1:0] m, input logic [7:0] b,
			input logic typed = 1'b0, input pixel_t want = NO_PIXEL);
		int     gap;
		logic   has_px;
		logic   took;
		pixel_t px;
		gap = tx_burst ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		tga_decode(m, b, has_px, px, took);
		bytes_sent++;
		if (took)
			busy_reqs++;
		if (has_px)
			pending_pixels.push_back(typed ? want : px);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [29:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_COLOR_MAPPED: regs.color_mapped = val[0];
			CFG_RUN_LENGTH:   regs.run_length   = val[0];
			CFG_PIXEL_BYTES:  regs.pixel_bytes  = val[2:0];
			CFG_MAP_BYTES:    regs.map_bytes    = val[2:0];
			CFG_TOTAL_PIXELS: regs.total_pixels = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_directed();
		step_t plan[$];
		plan = '{
			'{ROW_REQ,     MODE_IMAGE,       30'hAA, NO_PIXEL},
			'{ROW_REG,     CFG_TOTAL_PIXELS, 30'd4,  NO_PIXEL},
			'{ROW_REG,     CFG_PIXEL_BYTES,  30'd2,  NO_PIXEL},
			'{ROW_REQ,     MODE_IMAGE,       30'h00, NO_PIXEL},
			'{ROW_CHECKED, MODE_IMAGE,       30'h00, '{32'h0000_0000, 8'd1, 1'b0, 1'b0}},
			'{ROW_REQ,     MODE_IMAGE,       30'hFF, NO_PIXEL},
			'{ROW_CHECKED, MODE_IMAGE,       30'hFF, '{32'hFFFF_FFFF, 8'd1, 1'b0, 1'b0}},
			'{ROW_REG,     CFG_PIXEL_BYTES,  30'd0,  NO_PIXEL},
			'{ROW_CHECKED, MODE_IMAGE,       30'h5A, '{32'h0000_0000, 8'd1, 1'b0, 1'b0}},
			'{ROW_REG,     CFG_PIXEL_BYTES,  30'd7,  NO_PIXEL},
			'{ROW_REQ,     MODE_IMAGE,       30'h11, NO_PIXEL},
			'{ROW_REQ,     MODE_IMAGE,       30'h22, NO_PIXEL},
			'{ROW_REQ,     MODE_IMAGE,       30'h33, NO_PIXEL},
			'{ROW_CHECKED, MODE_IMAGE,       30'h44, '{32'h4433_2211, 8'd1, 1'b1, 1'b0}},
			'{ROW_REQ,     MODE_IMAGE,       30'h99, NO_PIXEL},
			'{ROW_REQ,     MODE_SPARE,       30'h00, NO_PIXEL},
			'{ROW_REQ,     MODE_FRAME,       30'h00, NO_PIXEL},
			'{ROW_REG,     CFG_MAP_BYTES,    30'd2,  NO_PIXEL},
			'{ROW_REQ,     MODE_PALETTE,     30'h00, NO_PIXEL},
			'{ROW_REQ,     MODE_PALETTE,     30'h80, NO_PIXEL},
			'{ROW_REG,     CFG_MAP_BYTES,    30'd7,  NO_PIXEL},
			'{ROW_REQ,     MODE_PALETTE,     30'h01, NO_PIXEL},
			'{ROW_REQ,     MODE_PALETTE,     30'h02, NO_PIXEL},
			'{ROW_REQ,     MODE_PALETTE,     30'h03, NO_PIXEL},
			'{ROW_REQ,     MODE_PALETTE,     30'h04, NO_PIXEL},
			'{ROW_REG,     CFG_COLOR_MAPPED, 30'd1,  NO_PIXEL},
			'{ROW_REG,     CFG_PIXEL_BYTES,  30'd1,  NO_PIXEL},
			'{ROW_REG,     CFG_RUN_LENGTH,   30'd1,  NO_PIXEL},
			'{ROW_REG,     CFG_TOTAL_PIXELS, 30'd10, NO_PIXEL},
			'{ROW_REQ,     MODE_IMAGE,       30'h82, NO_PIXEL},
			'{ROW_CHECKED, MODE_IMAGE,       30'h00, '{32'hFF00_0000, 8'd3, 1'b0, 1'b0}},
			'{ROW_REQ,     MODE_IMAGE,       30'h01, NO_PIXEL},
			'{ROW_REQ,     MODE_IMAGE,       30'h01, NO_PIXEL},
			'{ROW_REQ,     MODE_IMAGE,       30'h00, NO_PIXEL},
			'{ROW_REQ,     MODE_IMAGE,       30'hFF, NO_PIXEL},
			'{ROW_CHECKED, MODE_IMAGE,       30'h01, '{32'h0403_0201, 8'd5, 1'b1, 1'b1}},
			'{ROW_REQ,     MODE_IMAGE,       30'h33, NO_PIXEL}
		};
		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_REG: begin
					settle();
					write_reg(plan[i].sel, plan[i].arg);
				end
				ROW_REQ:     send_req(plan[i].sel[1:0], plan[i].arg[7:0]);
				ROW_CHECKED: send_req(plan[i].sel[1:0], plan[i].arg[7:0], 1'b1, plan[i].want);
				default: ;
			endcase
		end
	endtask

	// writes every palette slot, then a few entries that must be dropped
	task automatic fill_palette();
		settle();
		write_reg(CFG_MAP_BYTES, 30'd2);
		send_req(MODE_FRAME, 8'($urandom_range(0, 255)));
		for (int i = 0; i < (PAL_ENTRIES + 4) * 2; i++) begin
			if (i % 64 == 0)
				tx_burst = ($urandom_range(0, 2) == 0);
			send_req(MODE_PALETTE, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_phase();
		logic        mapped;
		logic [29:0] total;
		logic [7:0]  hdr;
		int          budget;
		mapped = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0:       total = 30'd0;
			1:       total = 30'h3FFF_FFFF;
			2:       total = 30'($urandom_range(1, 400));
			default: total = 30'($urandom_range(1, 30));
		endcase
		settle();
		write_reg(CFG_COLOR_MAPPED, {29'd0, mapped});
		write_reg(CFG_RUN_LENGTH, 30'($urandom_range(0, 1)));
		if ($urandom_range(0, 4) == 0)
			write_reg(CFG_PIXEL_BYTES, 30'($urandom_range(0, 7)));
		else
			write_reg(CFG_PIXEL_BYTES, mapped ? 30'd1 : 30'($urandom_range(2, 4)));
		if ($urandom_range(0, 4) == 0)
			write_reg(CFG_MAP_BYTES, 30'($urandom_range(0, 7)));
		else
			write_reg(CFG_MAP_BYTES, 30'($urandom_range(2, 4)));
		write_reg(CFG_TOTAL_PIXELS, total);
		frames++;
		tx_burst = ($urandom_range(0, 3) == 0);
		send_req(MODE_FRAME, 8'($urandom_range(0, 255)));
		repeat ($urandom_range(0, 3) * byte_count(regs.map_bytes))
			send_req(MODE_PALETTE, 8'($urandom_range(0, 255)));
		budget = $urandom_range(20, 120);
		while (budget > 0 && px_done < regs.total_pixels) begin
			if ($urandom_range(0, 19) == 0) begin
				send_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else if (regs.run_length && want_header) begin
				hdr[7]   = 1'($urandom_range(0, 1));
				hdr[6:0] = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
				                                        : 7'($urandom_range(0, 7));
				send_req(MODE_IMAGE, hdr);
			end else begin
				send_req(MODE_IMAGE, 8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 29) == 0)
				drain();
			budget--;
		end
		repeat ($urandom_range(0, 2))
			send_req(MODE_IMAGE, 8'($urandom_range(0, 255)));
	endtask

	task automatic check_pixel();
		pixel_t want;
		pixels_seen++;
		if (pending_pixels.size() == 0) begin
			report("unexpected result, argb", argb, 32'd0);
			return;
		end
		want = pending_pixels.pop_front();
		if (argb !== want.argb)
			report("argb", argb, want.argb);
		if (repeat_res !== want.reps)
			report("repeat_res", {24'd0, repeat_res}, {24'd0, want.reps});
		if (frame_done !== want.done)
			report("frame_done", {31'd0, frame_done}, {31'd0, want.done});
		if (clipped !== want.clip)
			report("clipped", {31'd0, clipped}, {31'd0, want.clip});
	endtask

	initial begin : result_side
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = rx_burst ? 0 : $urandom_range(0, 12);
			if (n > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			check_pixel();
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("No handshake for %0d cycles, %0d results outstanding", IDLE_LIMIT,
				pending_pixels.size());
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		in_valid  = 1'b0;
		mode      = MODE_PALETTE;
		data_byte = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_COLOR_MAPPED;
		cfg_data  = '0;
		regs.color_mapped = 1'b0;
		regs.run_length   = 1'b0;
		regs.pixel_bytes  = 3'd3;
		regs.map_bytes    = 3'd3;
		regs.total_pixels = '0;
		foreach (pal_mem[i])
			pal_mem[i] = '0;
		restart_frame();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		fill_palette();
		busy_reqs = 0;
		while (busy_reqs < RAND_ITEMS)
			run_phase();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d requests over %0d random frames after the directed rows and a full",
			bytes_sent, frames);
		$display("palette load with overflow; %0d register writes, %0d pixels checked.",
			reg_writes, pixels_seen);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ tga_pixel_stream_decoder.f @@
rtl/tpsd_pkg.sv
rtl/tpsd_palette.sv
rtl/tpsd_ctrl.sv
rtl/tga_pixel_stream_decoder.sv
bench/testbench.sv
